FILE: hw/rtl/cffr_pkg.sv
// Package for the contact force frame rotation unit.
// Payload structs and fixed-point constants; no dependencies.
package cffr_pkg;
  localparam int NW = 16;
  localparam int FW = 24;
  localparam int SCALE_FRAC = 16;
  // force fraction bits; forces pass through in their own format
  localparam int FORCE_FRAC = 8;

  typedef struct packed {
    logic signed [NW-1:0] normal_x;
    logic signed [NW-1:0] normal_y;
    logic signed [NW-1:0] normal_z;
    logic signed [FW-1:0] force_x;
    logic signed [FW-1:0] force_y;
    logic signed [FW-1:0] force_z;
  } in_item_t;

  typedef struct packed {
    logic signed [FW-1:0] world_force_x;
    logic signed [FW-1:0] world_force_y;
    logic signed [FW-1:0] world_force_z;
    logic                 identity_used;
  } out_item_t;

  // Rounded shift of a signed 96-bit value, ties toward plus infinity.
  function automatic logic signed [95:0] rnd(input logic signed [95:0] v, input int sh);
    logic signed [95:0] h;
    h = (sh == 0) ? 96'sd0 : (96'sd1 <<< (sh - 1));
    rnd = (v + h) >>> sh;
  endfunction

  function automatic logic signed [FW-1:0] sat24(input logic signed [95:0] v);
    if (v > 96'sd8388607) sat24 = 24'sh7FFFFF;
    else if (v < -96'sd8388608) sat24 = 24'sh800000;
    else sat24 = v[FW-1:0];
  endfunction
endpackage

FILE: hw/rtl/cffr_if.sv
// Valid/ready channel interface carrying one payload struct.
// Payload type is a parameter; used with cffr_pkg structs.
interface cffr_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/cffr_front.sv
// Front stage: computes tilt s2, classifies identity, forms U.
// Depends on cffr_pkg.
module cffr_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cffr_pkg::in_item_t   in_data,
  input  logic [31:0]          floor_val,
  output logic                 q_valid,
  input  logic                 q_ready,
  output cffr_pkg::in_item_t   q_item,
  output logic [32:0]          q_s2,
  output logic signed [47:0]   q_u,
  output logic                 q_ident
);
  import cffr_pkg::*;
  logic [32:0] s2;
  assign s2 = 33'(unsigned'(32'(in_data.normal_x * in_data.normal_x)))
            + 33'(unsigned'(32'(in_data.normal_y * in_data.normal_y)));
  assign in_ready = !q_valid || q_ready;
  always_ff @(posedge clk) begin
    if (!rst_n) q_valid <= 1'b0;
    else if (in_ready) q_valid <= in_valid;
    if (in_ready && in_valid) begin
      q_item  <= in_data;
      q_s2    <= s2;
      q_ident <= (s2 == 33'd0) || (s2 < {1'b0, floor_val});
      q_u     <= 48'(in_data.normal_x * in_data.force_x)
               + 48'(in_data.normal_y * in_data.force_y);
    end
  end
endmodule

FILE: hw/rtl/cffr_back.sv
// Back part: pipelined restoring divider for k, then the rotation products.
// Depends on cffr_pkg.
module cffr_back #(
  parameter int NFB = 15
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 s_valid,
  output logic                 s_ready,
  input  cffr_pkg::in_item_t   s_item,
  input  logic [32:0]          s_s2,
  input  logic signed [47:0]   s_u,
  input  logic                 s_ident,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cffr_pkg::out_item_t  out_data
);
  import cffr_pkg::*;
  localparam int DB = NFB + SCALE_FRAC;  // dividend shift; k has SCALE_FRAC fraction bits
  localparam int QB = 31;                // quotient bits below saturation
  localparam int ST = QB + 4;            // stages: entry, div, then 3 math
  typedef struct packed {
    in_item_t             it;
    logic [32:0]          den;
    logic signed [47:0]   u;
    logic                 id;
    logic                 neg;
    logic [63:0]          rem;
    logic [QB-1:0]        lo;
    logic [31:0]          q;
    logic                 sat;
    logic signed [47:0]   uf;
    logic signed [63:0]   g;
    logic signed [63:0]   px;
    logic signed [63:0]   py;
  } pl_t;
  pl_t  p_r [ST];
  logic v_r [ST];
  logic adv;
  assign adv = !v_r[ST-1] || out_ready;
  assign s_ready = adv;
  assign out_valid = v_r[ST-1];

  logic signed [31:0] a;
  logic [31:0] amag;
  logic [31:0] aabs;
  logic [32:0] den_in;
  logic [95:0] dvd;
  logic [95:0] dvd_hi;
  pl_t         ent;
  assign a = 32'sd1 <<< NFB;
  always_comb amag = 32'(a - 32'(s_item.normal_z));
  always_comb aabs = amag[31] ? -amag : amag;
  assign den_in = (s_s2 == 33'd0) ? 33'd1 : s_s2;
  // dividend |1-c| * 2^DB; its top part sits above the 31 quotient bits
  assign dvd    = 96'(aabs) << DB;
  assign dvd_hi = dvd >> QB;

  // entry: k saturates when the top part already reaches the divisor
  always_comb begin
    ent     = '0;
    ent.it  = s_item;
    ent.den = den_in;
    ent.u   = s_u;
    ent.id  = s_ident;
    ent.neg = amag[31];
    ent.rem = dvd_hi[63:0];
    ent.lo  = dvd[QB-1:0];
    ent.sat = dvd_hi >= 96'(den_in);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ST; i++) v_r[i] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= s_valid;
      for (int i = 1; i < ST; i++) v_r[i] <= v_r[i-1];
    end
    if (adv) begin
      p_r[0] <= ent;
      // one quotient bit per stage, low dividend bits shifted in
      for (int i = 1; i <= QB; i++) begin : div
        pl_t d;
        logic [64:0] r2;
        d = p_r[i-1];
        r2 = {d.rem, d.lo[QB-1]};
        d.lo = {d.lo[QB-2:0], 1'b0};
        d.q = {d.q[30:0], 1'b0};
        if (r2 >= 65'(d.den)) begin
          r2 = r2 - 65'(d.den);
          d.q[0] = 1'b1;
        end
        d.rem = r2[63:0];
        p_r[i] <= d;
      end
      // uf, and k clamped on saturation
      begin : s1
        pl_t d;
        logic signed [95:0] t;
        d = p_r[QB];
        t = rnd(96'(d.u), NFB);
        d.uf = (t > 96'sh7FFFFFFF) ? 48'sh7FFFFFFF :
               (t < -96'sh7FFFFFFF) ? -48'sh7FFFFFFF : t[47:0];
        if (d.sat) d.q = 32'h7FFFFFFF;
        p_r[QB+1] <= d;
      end
      // g = rnd(k*uf) + fz
      begin : s2b
        pl_t d;
        logic signed [32:0] k;
        logic signed [64:0] kp;
        logic signed [95:0] t;
        d = p_r[QB+1];
        k = d.neg ? -signed'({1'b0, d.q}) : signed'({1'b0, d.q});
        kp = k * $signed(d.uf[31:0]);
        t = rnd(96'(kp), SCALE_FRAC) + 96'(d.it.force_z);
        d.g = t[63:0];
        p_r[QB+2] <= d;
      end
      // products
      begin : s3
        pl_t d;
        d = p_r[QB+2];
        d.px = 64'(rnd(96'(d.it.normal_x) * 96'(d.g), NFB));
        d.py = 64'(rnd(96'(d.it.normal_y) * 96'(d.g), NFB));
        d.g  = 64'(rnd(96'(d.it.normal_z) * 96'(d.it.force_z) + 96'(d.u), NFB));
        p_r[QB+3] <= d;
      end
    end
  end

  always_comb begin
    if (p_r[ST-1].id) begin
      out_data.world_force_x = p_r[ST-1].it.force_x;
      out_data.world_force_y = p_r[ST-1].it.force_y;
      out_data.world_force_z = p_r[ST-1].it.force_z;
    end else begin
      out_data.world_force_x = sat24(96'(p_r[ST-1].it.force_x) - 96'(p_r[ST-1].px));
      out_data.world_force_y = sat24(96'(p_r[ST-1].it.force_y) - 96'(p_r[ST-1].py));
      out_data.world_force_z = sat24(96'(p_r[ST-1].g));
    end
    out_data.identity_used = p_r[ST-1].id;
  end
endmodule

FILE: hw/rtl/contact_force_frame_rotation_unit.sv
// Top level of the contact force frame rotation unit.
// Uses cffr_pkg, cffr_if, cffr_front and cffr_back.
//
// Channels: in (normal + contact-frame force), out (world-frame force and
// identity flag), cfg (tilt_floor write; the user must write it only while the block is idle, not enforced here).
// Each transaction is valid/ready; one item per cycle is accepted while out does not stall.
// Pipeline from accept to result valid: front stage, divider
// entry stage, 31 quotient-bit stages, three math stages.
// Throughput: one item per cycle while out does not stall, set by the fully pipelined divider.
// Reset: rst_n low clears all valid bits and sets tilt_floor to 1.
// When out stalls, the back pipeline holds and the front register fills,
// then in_ready drops; nothing is lost or repeated.
module contact_force_frame_rotation_unit #(
  parameter int NORMAL_FRAC_BITS = 15
) (
  input  logic clk,
  input  logic rst_n,
  cffr_if.sink   in_ch,
  cffr_if.source out_ch,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  import cffr_pkg::*;
  logic [31:0] floor_r;
  logic q_valid, q_ready, q_ident;
  in_item_t q_item;
  logic [32:0] q_s2;
  logic signed [47:0] q_u;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) floor_r <= 32'd1;
    else if (cfg_valid) floor_r <= cfg_data;
  end

  cffr_front u_front (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .floor_val(floor_r), .q_valid, .q_ready, .q_item, .q_s2, .q_u, .q_ident);

  cffr_back #(.NFB(NORMAL_FRAC_BITS)) u_back (
    .clk, .rst_n, .s_valid(q_valid), .s_ready(q_ready), .s_item(q_item), .s_s2(q_s2),
    .s_u(q_u), .s_ident(q_ident), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_data(out_ch.data));
endmodule

FILE: sim/cffr_checker.sv
// Checker for the contact force frame rotation unit: predicts world-frame force.
// Watches in/out/cfg channels; depends on cffr_pkg.
module cffr_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  cffr_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  cffr_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [31:0]         cfg_data,
  output int                  fail_count,
  output int                  pending
);
  import cffr_pkg::*;

  localparam int NFRAC = 15;
  localparam longint KMAX = 64'h7FFF_FFFF;

  logic [31:0] floor_q;
  out_item_t   world_q[$];

  function automatic longint round_shift(longint v, int sh);
    longint h;
    h = 64'sd1 <<< (sh - 1);
    return (v + h) >>> sh;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // floor(a * 2^31 / s2) saturated, bit by bit like a restoring divider
  function automatic longint scale_mag(longint a, longint s2);
    longint q, r;
    q = a / s2;
    r = a % s2;
    if (q > KMAX) return KMAX;
    for (int i = 0; i < NFRAC + SCALE_FRAC; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= s2) begin
        q = q | 1;
        r = r - s2;
      end
      if (q > KMAX) return KMAX;
    end
    return q;
  endfunction

  function automatic out_item_t rotate_force(in_item_t it, logic [31:0] flr);
    out_item_t o;
    longint nx, ny, nz, fx, fy, fz, s2, a, k, u, uf, g;
    longint wx, wy, wz;
    nx = it.normal_x; ny = it.normal_y; nz = it.normal_z;
    fx = it.force_x;  fy = it.force_y;  fz = it.force_z;
    s2 = nx * nx + ny * ny;
    o.identity_used = (s2 == 0) || (s2 < longint'(flr));
    if (o.identity_used) begin
      wx = fx; wy = fy; wz = fz;
    end else begin
      a = (64'sd1 <<< NFRAC) - nz;
      k = scale_mag(a < 0 ? -a : a, s2);
      if (a < 0) k = -k;
      u = nx * fx + ny * fy;
      uf = clamp(round_shift(u, NFRAC), -KMAX, KMAX);
      g = round_shift(k * uf, SCALE_FRAC) + fz;
      wx = fx - round_shift(nx * g, NFRAC);
      wy = fy - round_shift(ny * g, NFRAC);
      wz = round_shift(nz * fz + u, NFRAC);
    end
    o.world_force_x = 24'(clamp(wx, -8388608, 8388607));
    o.world_force_y = 24'(clamp(wy, -8388608, 8388607));
    o.world_force_z = 24'(clamp(wz, -8388608, 8388607));
    return o;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    fail_count++;
  endtask

  assign pending = world_q.size();

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      floor_q <= 32'd1;
      world_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (world_q.size() == 0) begin
          report("unexpected transaction", 0, 0);
        end else begin
          want = world_q.pop_front();
          if (out_data.world_force_x !== want.world_force_x)
            report("world_force_x", out_data.world_force_x, want.world_force_x);
          if (out_data.world_force_y !== want.world_force_y)
            report("world_force_y", out_data.world_force_y, want.world_force_y);
          if (out_data.world_force_z !== want.world_force_z)
            report("world_force_z", out_data.world_force_z, want.world_force_z);
          if (out_data.identity_used !== want.identity_used)
            report("identity_used", out_data.identity_used, want.identity_used);
        end
      end
      if (in_valid && in_ready)
        world_q.insert(world_q.size(), rotate_force(in_data, floor_q));
      if (cfg_valid && cfg_ready) floor_q <= cfg_data;
    end
  end
endmodule

FILE: sim/tb_contact_force_frame_rotation_unit.sv
// Testbench top for the contact force frame rotation unit: stimulus and verdict.
// Depends on cffr_pkg, cffr_if, the unit and cffr_checker.
module tb_contact_force_frame_rotation_unit;
  import cffr_pkg::*;

  localparam int LATENCY = 36;          // extra drain wait once no result is pending
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;
  int fail_count, pending;
  int cycle_count = 0;

  always #5 clk = ~clk;

  cffr_if #(.T(in_item_t))  in_ch  ();
  cffr_if #(.T(out_item_t)) out_ch ();

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  contact_force_frame_rotation_unit i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  cffr_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // Hard stop: well over the slowest legal run of 853 items with maximal gaps and stalls.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: per transaction, a random stall, often none.
  initial begin
    int stall;
    @(posedge clk iff rst_n);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (($urandom_range(0, 400) < 40)) stall = 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk iff out_ch.valid);
    end
  end

  bit quiet_phase;  // sender runs back to back

  // One transaction on the input channel, with a random gap first.
  task automatic send_item(in_item_t it);
    int gap;
    gap = quiet_phase ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk iff in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_floor(logic [31:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk iff cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t make_item(logic signed [15:0] nx, logic signed [15:0] ny,
                                         logic signed [15:0] nz, logic signed [23:0] fx,
                                         logic signed [23:0] fy, logic signed [23:0] fz);
    in_item_t it;
    it.normal_x = nx; it.normal_y = ny; it.normal_z = nz;
    it.force_x = fx; it.force_y = fy; it.force_z = fz;
    return it;
  endfunction

  // Half near-unit normals with random small tilt; some tiny tilts on raw bits; the rest raw bits.
  function automatic in_item_t random_item();
    in_item_t it;
    int kind;
    kind = $urandom_range(0, 9);
    it = in_item_t'({$urandom, $urandom, $urandom, $urandom});
    if (kind < 5) begin
      it.normal_x = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
      it.normal_y = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
      it.normal_z = 16'sd32767 - 16'($urandom_range(0, 900));
      it.force_x = $signed(24'($urandom_range(0, 400000))) - 24'sd200000;
      it.force_y = $signed(24'($urandom_range(0, 400000))) - 24'sd200000;
      it.force_z = $signed(24'($urandom_range(0, 400000)));
    end else if (kind == 5) begin
      it.normal_x = $signed(16'($urandom_range(0, 6))) - 16'sd3;
      it.normal_y = $signed(16'($urandom_range(0, 6))) - 16'sd3;
    end
    return it;
  endfunction

  initial begin
    logic [31:0] floors[6];
    floors = '{32'd0, 32'd4096, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF, 32'd50000};
    quiet_phase = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: axis normals, zero tilt, near flip, extremes, saturation.
    send_item(make_item(16'sd0, 16'sd0, 16'sd32767, 24'sd256, -24'sd256, 24'sd1000));
    send_item(make_item(16'sd0, 16'sd0, 16'sd0, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF));
    send_item(make_item(16'sd1, 16'sd0, 16'sd32767, 24'sd5, 24'sd5, 24'sd5));
    send_item(make_item(16'sd32767, 16'sd0, 16'sd0, 24'sd1000, 24'sd2000, 24'sd3000));
    send_item(make_item(16'sd0, 16'sh8000, 16'sd0, 24'sh800000, 24'sh7FFFFF,
                        24'sh800000));
    send_item(make_item(16'sd1, 16'sd1, 16'sh8000, 24'sd100000, 24'sd100000, 24'sd1));
    send_item(make_item(16'sh8000, 16'sh8000, 16'sh8000, 24'sh7FFFFF, 24'sh7FFFFF,
                        24'sh7FFFFF));
    send_item(make_item(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 24'sh800000, 24'sh800000,
                        24'sh800000));
    send_item(make_item(16'sd23170, 16'sd0, 16'sd23170, 24'sh7FFFFF, 24'sd0,
                        24'sh7FFFFF));
    send_item(make_item(-16'sd1, 16'sd2, 16'sd32767, -24'sd1, 24'sd1, 24'sd0));
    send_item(make_item(16'sd3, 16'sd4, 16'sh7FFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sd0));
    send_item(make_item(16'sd200, -16'sd300, -16'sd32000, 24'sd70000, -24'sd5000,
                        24'sd9000));

    // Random phases, one per tilt floor setting (extremes included).
    for (int p = 0; p < 6; p++) begin
      write_floor(floors[p]);
      quiet_phase = (p == 2);
      if (p == 0) send_item(make_item(16'sd0, 16'sd0, 16'sd0, 24'sd7, 24'sd8, 24'sd9));
      for (int i = 0; i < 140; i++) send_item(random_item());
    end

    drain();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
